[rtl/ssr_pkg.sv]
package ssr_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_MOVE = 2'd2;

    // Configuration register indexes
    localparam logic REG_ENABLE   = 1'b0;
    localparam logic REG_DEADZONE = 1'b1;

    localparam int ANGLE_W    = 16;
    localparam int SPEED_W    = 8;
    localparam int POS_W      = 8;
    localparam int IVL_W      = 5;
    localparam int DUTY_W     = 13;
    localparam int DZ_W       = 4;

    localparam logic [POS_W-1:0]  ANGLE_MAX   = 8'd180;
    localparam logic [POS_W-1:0]  POS_RESET   = 8'd90;
    localparam logic [IVL_W-1:0]  IVL_RESET   = 5'd20;
    localparam logic [IVL_W-1:0]  IVL_SLOWEST = 5'd20;
    localparam logic [DZ_W-1:0]   DZ_RESET    = 4'd2;
    localparam logic [DUTY_W-1:0] DUTY_MIN    = 13'd1638;

    // floor(s*19/99) as (s * 19 * 662) >> 16, exact for s in 0..99
    localparam logic [13:0] IVL_RECIP = 14'd12578;
    // floor(p*6226/180) as (p * 6226 * ceil(2^28/180)) >> 28, exact for p in 0..180
    localparam logic [33:0] DUTY_RECIP = 34'd9284889834;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] target;
        logic [IVL_W-1:0] interval;
        logic [IVL_W-1:0] countdown;
        logic             active;
    } t_ramp_state;

    // Clamp a signed request to 0..180 degrees
    function automatic logic [POS_W-1:0] clamp_angle(input logic signed [ANGLE_W-1:0] a);
        logic [POS_W-1:0] r;
        if (a < 0) begin
            r = '0;
        end else if (a > $signed({{(ANGLE_W-POS_W){1'b0}}, ANGLE_MAX})) begin
            r = ANGLE_MAX;
        end else begin
            r = a[POS_W-1:0];
        end
        return r;
    endfunction

    // Ticks per one-degree step for a raw speed
    function automatic logic [IVL_W-1:0] speed_interval(input logic [SPEED_W-1:0] spd);
        logic [6:0]  s;
        logic [20:0] prod;
        if (spd == '0) begin
            s = '0;
        end else if (spd > 8'd100) begin
            s = 7'd99;
        end else begin
            s = 7'(spd - 8'd1);
        end
        prod = 21'(s) * 21'(IVL_RECIP);
        return IVL_SLOWEST - prod[20:16];
    endfunction

    // PWM duty for a position
    function automatic logic [DUTY_W-1:0] pos_duty(input logic [POS_W-1:0] pos);
        logic [41:0] prod;
        prod = 42'(pos) * 42'(DUTY_RECIP);
        return prod[40:28] + DUTY_MIN;
    endfunction

endpackage

[rtl/ssr_step.sv]
module ssr_step (
    input  ssr_pkg::t_ramp_state                  i_state,
    input  logic [1:0]                            i_op,
    input  logic signed [ssr_pkg::ANGLE_W-1:0]    i_angle,
    input  logic [ssr_pkg::SPEED_W-1:0]           i_speed,
    input  logic                                  i_enabled,
    input  logic [ssr_pkg::DZ_W-1:0]              i_deadzone,
    output ssr_pkg::t_ramp_state                  o_state,
    output logic                                  o_update
);

    logic [ssr_pkg::POS_W-1:0] req;
    logic [ssr_pkg::POS_W-1:0] delta;
    logic [ssr_pkg::IVL_W-1:0] ivl;

    assign req   = ssr_pkg::clamp_angle(i_angle);
    assign delta = (req > i_state.position) ? req - i_state.position : i_state.position - req;
    assign ivl   = ssr_pkg::speed_interval(i_speed);

    // Work out the next ramp state for one beat
    always_comb begin
        o_state  = i_state;
        o_update = 1'b0;
        case (i_op)
            ssr_pkg::OP_TICK: begin
                if (i_state.active) begin
                    if (i_state.countdown > 5'd1) begin
                        o_state.countdown = i_state.countdown - 5'd1;
                    end else if (i_state.position == i_state.target) begin
                        o_state.active    = 1'b0;
                        o_state.countdown = '0;
                    end else begin
                        if (i_state.position < i_state.target) begin
                            o_state.position = i_state.position + 8'd1;
                        end else begin
                            o_state.position = i_state.position - 8'd1;
                        end
                        o_state.countdown = i_state.interval;
                        o_update          = 1'b1;
                    end
                end
            end
            ssr_pkg::OP_SET: begin
                if (i_enabled) begin
                    o_state.position  = req;
                    o_state.target    = req;
                    o_state.active    = 1'b0;
                    o_state.countdown = '0;
                    o_update          = 1'b1;
                end
            end
            ssr_pkg::OP_MOVE: begin
                if (i_enabled && (delta > {4'd0, i_deadzone})) begin
                    o_state.target    = req;
                    o_state.interval  = ivl;
                    o_state.active    = 1'b1;
                    o_state.countdown = ivl;
                    if (i_state.position < req) begin
                        o_state.position = i_state.position + 8'd1;
                    end else if (i_state.position > req) begin
                        o_state.position = i_state.position - 8'd1;
                    end
                    o_update = 1'b1;
                end
            end
            default: begin
                o_update = 1'b0;
            end
        endcase
    end

endmodule

[rtl/servo_slew_rate_ramp.sv]
// Channel   Dir  Bits  Contents
// s_axis    in   24/2  tdata: angle[15:0], speed[23:16]; tuser: operation
// m_axis    out  24/1  tdata: duty[12:0], position[20:13], moving[21]; tuser: duty_update
// cfg       in   1/4   index 0 output_enabled, index 1 deadzone_degrees
//
// One beat is accepted every cycle while the result side does not stall; its result is formed
// through the input register, then the ramp update and duty multiply into the result register.
// Reset gives position 90, interval 20, no move, output disabled, deadzone 2.
// A stalled result holds the pipeline; tready drops only when both registers are full
// and the result is not being taken.
module servo_slew_rate_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // angle[15:0], speed[23:16]
    input  logic [1:0]  i_s_axis_tuser,   // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // duty[12:0], position[20:13], moving[21], zero[23:22]
    output logic        o_m_axis_tuser,   // duty_update[0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_wdata
);

    logic                           r_in_valid;
    logic [1:0]                     r_op;
    logic [ssr_pkg::ANGLE_W-1:0]    r_angle;
    logic [ssr_pkg::SPEED_W-1:0]    r_speed;

    logic                           r_out_valid;
    logic                           r_update;
    logic [ssr_pkg::DUTY_W-1:0]     r_duty;
    logic [ssr_pkg::POS_W-1:0]      r_position;
    logic                           r_moving;

    logic                           r_enabled;
    logic [ssr_pkg::DZ_W-1:0]       r_deadzone;
    ssr_pkg::t_ramp_state           r_state;
    ssr_pkg::t_ramp_state           n_state;
    logic                           n_update;

    logic                           advance;

    // Move the input register on whenever the result register is free
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    ssr_step u_step (
        .i_state    (r_state),
        .i_op       (r_op),
        .i_angle    (r_angle),
        .i_speed    (r_speed),
        .i_enabled  (r_enabled),
        .i_deadzone (r_deadzone),
        .o_state    (n_state),
        .o_update   (n_update)
    );

    // Capture input beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_op    <= i_s_axis_tuser;
            r_angle <= i_s_axis_tdata[15:0];
            r_speed <= i_s_axis_tdata[23:16];
        end
    end

    // Update ramp state, load the result, take config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_enabled   <= 1'b0;
            r_deadzone  <= ssr_pkg::DZ_RESET;
            r_state     <= '{position:  ssr_pkg::POS_RESET,
                             target:    ssr_pkg::POS_RESET,
                             interval:  ssr_pkg::IVL_RESET,
                             countdown: '0,
                             active:    1'b0};
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ssr_pkg::REG_ENABLE: begin
                        r_enabled <= i_cfg_wdata[0];
                        if (!i_cfg_wdata[0]) begin
                            r_state.active    <= 1'b0;
                            r_state.countdown <= '0;
                        end
                    end
                    ssr_pkg::REG_DEADZONE: begin
                        r_deadzone <= i_cfg_wdata;
                    end
                    default: begin
                        r_deadzone <= r_deadzone;
                    end
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_update   <= n_update;
            r_duty     <= ssr_pkg::pos_duty(n_state.position);
            r_position <= n_state.position;
            r_moving   <= n_state.active;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_moving, r_position, r_duty};
    assign o_m_axis_tuser  = r_update;

endmodule

[bench/servo_slew_rate_ramp_tb.sv]
module servo_slew_rate_ramp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // No operation: the fourth code of the operation field
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AT     = 450;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic                       upd;
        logic [ssr_pkg::DUTY_W-1:0] duty;
        logic [ssr_pkg::POS_W-1:0]  pos;
        logic                       mov;
    } t_ramp_out;

    typedef struct {
        t_row_kind          kind;
        logic [1:0]         op;
        logic signed [15:0] angle;
        logic [7:0]         speed;
        logic               fixed;
        t_ramp_out          want;
        logic               reg_idx;
        logic [3:0]         reg_val;
    } t_plan_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_data;
    logic [1:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_data;
    logic        m_user;
    logic        cfg_we;
    logic        cfg_idx;
    logic [3:0]  cfg_data;

    // Shadow of the ramp state and registers
    logic [ssr_pkg::POS_W-1:0] pr_pos;
    logic [ssr_pkg::POS_W-1:0] pr_tgt;
    logic [ssr_pkg::IVL_W-1:0] pr_ivl;
    logic [ssr_pkg::IVL_W-1:0] pr_cnt;
    logic                      pr_act;
    logic                      pr_en;
    logic [ssr_pkg::DZ_W-1:0]  pr_dz;

    t_ramp_out servo_expect_q[$];
    t_plan_row plan_q[$];
    int        sent_items = 0;
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    logic      no_idle = 1'b0;

    servo_slew_rate_ramp u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // angle[15:0], speed[23:16]
        .i_s_axis_tuser  (s_user),    // operation[1:0]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // duty[12:0], position[20:13], moving[21]
        .o_m_axis_tuser  (m_user),    // duty_update[0]
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_wdata     (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Move the shadow position one degree toward the target
    function automatic void ramp_step_once();
        if (pr_pos < pr_tgt) begin
            pr_pos = pr_pos + 1'b1;
        end else if (pr_pos > pr_tgt) begin
            pr_pos = pr_pos - 1'b1;
        end
    endfunction

    // Advance the shadow ramp by one command and form its result
    function automatic t_ramp_out ramp_predict(input logic [1:0] op,
                                               input logic signed [15:0] ang,
                                               input logic [7:0] spd);
        t_ramp_out                 r;
        logic [ssr_pkg::POS_W-1:0] t;
        int                        delta;
        int                        s;
        logic                      upd;
        upd = 1'b0;
        if (ang < 0) begin
            t = '0;
        end else if (ang > 16'sd180) begin
            t = ssr_pkg::ANGLE_MAX;
        end else begin
            t = ang[ssr_pkg::POS_W-1:0];
        end
        case (op)
            ssr_pkg::OP_TICK: begin
                if (pr_act) begin
                    if (pr_cnt > 1) begin
                        pr_cnt = pr_cnt - 1'b1;
                    end else if (pr_pos == pr_tgt) begin
                        pr_act = 1'b0;
                        pr_cnt = '0;
                    end else begin
                        ramp_step_once();
                        upd = 1'b1;
                        pr_cnt = pr_ivl;
                    end
                end
            end
            ssr_pkg::OP_SET: begin
                if (pr_en) begin
                    pr_tgt = t;
                    pr_pos = t;
                    pr_act = 1'b0;
                    pr_cnt = '0;
                    upd = 1'b1;
                end
            end
            ssr_pkg::OP_MOVE: begin
                if (pr_en) begin
                    delta = (t > pr_pos) ? int'(t - pr_pos) : int'(pr_pos - t);
                    if (delta > int'(pr_dz)) begin
                        s = int'(spd);
                        if (s < 1) s = 1;
                        if (s > 100) s = 100;
                        pr_tgt = t;
                        pr_ivl = ssr_pkg::IVL_SLOWEST - 5'(((s - 1) * 19) / 99);
                        pr_act = 1'b1;
                        ramp_step_once();
                        upd = 1'b1;
                        pr_cnt = pr_ivl;
                    end
                end
            end
            default: begin
            end
        endcase
        r.upd  = upd;
        r.duty = ssr_pkg::DUTY_W'((int'(pr_pos) * 6226) / 180 + int'(ssr_pkg::DUTY_MIN));
        r.pos  = pr_pos;
        r.mov  = pr_act;
        return r;
    endfunction

    // Directed rows: predicted, fixed expectation, register write
    function automatic void plan_item(input logic [1:0] op, input logic signed [15:0] ang,
                                      input logic [7:0] spd);
        t_plan_row row;
        row.kind = ROW_ITEM;
        row.op = op;
        row.angle = ang;
        row.speed = spd;
        row.fixed = 1'b0;
        row.want = '0;
        row.reg_idx = 1'b0;
        row.reg_val = '0;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_checked(input logic [1:0] op, input logic signed [15:0] ang,
                                         input logic [7:0] spd, input logic upd,
                                         input int duty, input int pos, input logic mov);
        t_plan_row row;
        row.kind = ROW_ITEM;
        row.op = op;
        row.angle = ang;
        row.speed = spd;
        row.fixed = 1'b1;
        row.want.upd = upd;
        row.want.duty = ssr_pkg::DUTY_W'(duty);
        row.want.pos = ssr_pkg::POS_W'(pos);
        row.want.mov = mov;
        row.reg_idx = 1'b0;
        row.reg_val = '0;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_reg(input logic idx, input logic [3:0] val);
        t_plan_row row;
        row.kind = ROW_CFG;
        row.op = ssr_pkg::OP_TICK;
        row.angle = '0;
        row.speed = '0;
        row.fixed = 1'b0;
        row.want = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        plan_q.push_back(row);
    endfunction

    // Pick a requested angle: full range, in range, or near the live position
    function automatic logic signed [15:0] pick_angle();
        int near;
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2, 3, 4: return 16'($urandom_range(0, 180));
            default: begin
                near = int'(pr_pos) + int'($urandom_range(0, 40)) - 20;
                return 16'(near);
            end
        endcase
    endfunction

    // Offer one command beat and log its expected result once taken
    task automatic push_command(input logic [1:0] op, input logic signed [15:0] ang,
                                input logic [7:0] spd, input logic fixed,
                                input t_ramp_out want);
        int        gap;
        t_ramp_out pred;
        no_idle = (sent_items % 150) < 30;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {spd, ang};
        s_user  <= op;
        do @(posedge clk); while (!s_ready);
        pred = ramp_predict(op, ang, spd);
        servo_expect_q.push_back(fixed ? want : pred);
        sent_items++;
    endtask

    // Stop offering beats and let every pending result drain
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (servo_expect_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register once the block is idle
    task automatic write_reg(input logic idx, input logic [3:0] val);
        settle_pipeline();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ssr_pkg::REG_ENABLE) begin
            pr_en = val[0];
            if (!val[0]) begin
                pr_act = 1'b0;
                pr_cnt = '0;
            end
        end else begin
            pr_dz = val;
        end
    endtask

    // One random burst: most often a move followed by a run of ticks, else a set, ticks alone or a no-op
    task automatic random_sequence();
        int                 r;
        int                 n;
        logic signed [15:0] ang;
        logic [7:0]         spd;
        r = $urandom_range(0, 99);
        ang = pick_angle();
        if (r < 55) begin
            spd = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(85, 110));
            push_command(ssr_pkg::OP_MOVE, ang, spd, 1'b0, '0);
            n = $urandom_range(0, 60);
            repeat (n) push_command(ssr_pkg::OP_TICK, 16'($urandom), 8'($urandom), 1'b0, '0);
        end else if (r < 68) begin
            push_command(ssr_pkg::OP_SET, ang, 8'($urandom), 1'b0, '0);
            n = $urandom_range(0, 4);
            repeat (n) push_command(ssr_pkg::OP_TICK, 16'($urandom), 8'($urandom), 1'b0, '0);
        end else if (r < 93) begin
            n = $urandom_range(1, 20);
            repeat (n) push_command(ssr_pkg::OP_TICK, 16'($urandom), 8'($urandom), 1'b0, '0);
        end else begin
            push_command(OP_NONE, 16'($urandom), 8'($urandom), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input logic en, input logic [3:0] dz, input int len);
        int start;
        write_reg(ssr_pkg::REG_ENABLE, {3'b000, en});
        write_reg(ssr_pkg::REG_DEADZONE, dz);
        start = sent_items;
        while (sent_items - start < len) random_sequence();
    endtask

    // Stimulus
    initial begin
        rst_n    = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        s_user   = ssr_pkg::OP_TICK;
        cfg_we   = 1'b0;
        cfg_idx  = ssr_pkg::REG_ENABLE;
        cfg_data = '0;
        pr_pos   = ssr_pkg::POS_RESET;
        pr_tgt   = ssr_pkg::POS_RESET;
        pr_ivl   = ssr_pkg::IVL_RESET;
        pr_cnt   = '0;
        pr_act   = 1'b0;
        pr_en    = 1'b0;
        pr_dz    = ssr_pkg::DZ_RESET;

        // Disabled after reset: set and move are ignored, nothing changes
        plan_checked(ssr_pkg::OP_TICK, 16'sd0, 8'd0, 1'b0, 4751, 90, 1'b0);
        plan_checked(ssr_pkg::OP_SET, -16'sd32768, 8'd0, 1'b0, 4751, 90, 1'b0);
        plan_checked(ssr_pkg::OP_MOVE, 16'sd0, 8'd100, 1'b0, 4751, 90, 1'b0);
        plan_checked(OP_NONE, 16'sd32767, 8'd255, 1'b0, 4751, 90, 1'b0);
        plan_reg(ssr_pkg::REG_ENABLE, 4'd1);
        // Angle extremes, then a move inside the deadzone
        plan_checked(ssr_pkg::OP_SET, -16'sd32768, 8'd0, 1'b1, 1638, 0, 1'b0);
        plan_checked(ssr_pkg::OP_SET, 16'sd32767, 8'd0, 1'b1, 7864, 180, 1'b0);
        plan_checked(ssr_pkg::OP_MOVE, 16'sd178, 8'd100, 1'b0, 7864, 180, 1'b0);
        // Slowest move, a deadzone miss while moving, then a fast restart
        plan_item(ssr_pkg::OP_MOVE, 16'sd0, 8'd0);
        plan_item(ssr_pkg::OP_TICK, 16'sd0, 8'd0);
        plan_item(ssr_pkg::OP_TICK, 16'sd0, 8'd0);
        plan_item(ssr_pkg::OP_MOVE, 16'sd177, 8'd255);
        plan_item(ssr_pkg::OP_MOVE, 16'sd174, 8'd255);
        repeat (5) plan_item(ssr_pkg::OP_TICK, -16'sd1, 8'd255);
        // Set while moving cancels the move
        plan_item(ssr_pkg::OP_MOVE, 16'sd0, 8'd50);
        plan_item(ssr_pkg::OP_SET, 16'sd45, 8'd0);
        plan_reg(ssr_pkg::REG_DEADZONE, 4'd15);
        plan_item(ssr_pkg::OP_MOVE, 16'sd60, 8'd100);
        plan_reg(ssr_pkg::REG_DEADZONE, 4'd0);
        plan_item(ssr_pkg::OP_MOVE, 16'sd46, 8'd100);
        plan_item(ssr_pkg::OP_TICK, 16'sd0, 8'd0);
        plan_item(ssr_pkg::OP_TICK, 16'sd0, 8'd0);
        // Disabling the output stops a running move
        plan_item(ssr_pkg::OP_MOVE, 16'sd150, 8'd1);
        plan_reg(ssr_pkg::REG_ENABLE, 4'd0);
        plan_item(ssr_pkg::OP_TICK, 16'sd0, 8'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan_q[i]) begin
            if (plan_q[i].kind == ROW_CFG) begin
                write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
            end else begin
                push_command(plan_q[i].op, plan_q[i].angle, plan_q[i].speed,
                             plan_q[i].fixed, plan_q[i].want);
            end
        end

        run_phase(1'b1, 4'd0, 300);
        run_phase(1'b1, 4'd15, 250);
        run_phase(1'b1, 4'($urandom), 300);
        run_phase(1'b0, 4'($urandom), 40);
        run_phase(1'b1, 4'd2, 300);
        run_phase(1'b1, 4'($urandom), 160);

        settle_pipeline();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random hold-offs, one long stall to back up the input
    initial begin : result_ready
        int gap;
        int seen;
        m_ready = 1'b0;
        seen = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (seen == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
            seen++;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin : result_check
        t_ramp_out got;
        t_ramp_out want;
        if (rst_n && m_valid && m_ready) begin
            got.upd  = m_user;
            got.duty = m_data[12:0];
            got.pos  = m_data[20:13];
            got.mov  = m_data[21];
            if (servo_expect_q.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result: upd=%0d duty=%0d pos=%0d mov=%0d",
                             got.upd, got.duty, got.pos, got.mov);
                end
                mismatch_count++;
            end else begin
                want = servo_expect_q.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: expected upd=%0d duty=%0d pos=%0d mov=%0d,",
                                 want.upd, want.duty, want.pos, want.mov,
                                 " got upd=%0d duty=%0d pos=%0d mov=%0d",
                                 got.upd, got.duty, got.pos, got.mov);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: give up when no beat moves for too long
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
